// ===== design/tss_pkg.sv =====
// Shared types and constants for the tween segment sequencer.
// No dependencies; imported by tss_alu, tss_core and tween_segment_sequencer.
package tss_pkg;

  localparam int          QBITS   = 16;
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [8:0]  PASS_SAT = 9'd256;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_PAUSE  = 3'd3;
  localparam logic [2:0] CMD_RESUME = 3'd4;
  localparam logic [2:0] CMD_TOGGLE = 3'd5;
  localparam logic [2:0] CMD_RESET  = 3'd6;

  localparam logic [2:0] REG_SEG_COUNT = 3'd0;
  localparam logic [2:0] REG_SEG_FIRST = 3'd1;
  localparam logic [2:0] REG_SEG_LAST  = 3'd4;

  localparam int IN_W = 24;

  typedef enum logic [1:0] {
    MODE_STOPPED   = 2'd0,
    MODE_STARTED   = 2'd1,
    MODE_PAUSED    = 2'd2,
    MODE_COMPLETED = 2'd3
  } mode_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // First member lands in the top bits; run state sits at bit 0.
  typedef struct packed {
    logic        dropped;
    logic        done_now;
    logic        advanced;
    logic        wrapped;
    logic        reversed;
    logic [8:0]  passes;
    logic [16:0] progress;
    logic [1:0]  seg;
    mode_t       mode;
  } res_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] dt;
    logic        force_start;
  } item_t;

  localparam int RES_W = $bits(res_t);
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

endpackage

// ===== design/tss_alu.sv =====
// Shared add/subtract unit of the tween segment sequencer.
// Depends on tss_pkg for the operation code.
module tss_alu #(
  parameter int W = 26
) (
  input  tss_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     y,
  output logic             borrow
);
  import tss_pkg::*;

  logic [W:0] ext;

  always_comb begin
    unique case (op)
      ALU_ADD: ext = {1'b0, a} + {1'b0, b};
      ALU_SUB: ext = {1'b0, a} - {1'b0, b};
    endcase
  end

  assign y      = ext[W-1:0];
  assign borrow = (op == ALU_SUB) && ext[W];

endmodule

// ===== design/tss_core.sv =====
// Sequencer of the tween segment sequencer: run state, pass loop and
// progress division, all through one tss_alu. Depends on tss_pkg, tss_alu.
module tss_core #(
  parameter int MAX_SEGMENTS       = 4,
  parameter int DURATION_BITS      = 24,
  parameter int MAX_WRAPS_PER_TICK = 8,
  localparam int WORD_W = DURATION_BITS + 11,
  localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
  localparam int UC_W   = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tss_pkg::item_t      item,
  output logic                in_ready,
  output logic [SEG_W-1:0]    cur_seg,
  input  logic [WORD_W-1:0]   cur_word,
  input  logic                word0_srev,
  input  logic [UC_W-1:0]     used_cnt,
  input  logic                out_free,
  output logic                res_valid,
  output tss_pkg::res_t       res
);
  import tss_pkg::*;

  localparam int DB   = DURATION_BITS;
  localparam int RW   = ((DB > 16) ? DB : 16) + 1;
  localparam int AW   = RW + 1;
  localparam int WR_W = $clog2(MAX_WRAPS_PER_TICK + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADD, ST_CMP, ST_LOADREV, ST_PREP, ST_DIV, ST_FIN
  } state_t;

  state_t            state;
  state_t            ret_state;
  mode_t             mode;
  logic [SEG_W-1:0]  seg;
  logic [DB-1:0]     elapsed;
  logic [8:0]        pass_counter;
  logic              rev;
  logic [RW-1:0]     dt;
  logic [AW-1:0]     sum;
  logic [DB-1:0]     rem;
  logic [16:0]       raw;
  logic [3:0]        bitcnt;
  logic [WR_W-1:0]   wraps;
  logic              wrapped, advanced, done_now, dropped;

  // segment word fields
  logic [DB-1:0] dur;
  logic [7:0]    reps;
  logic          inf_rep, yoyo, srev;

  assign dur     = cur_word[DB-1:0];
  assign reps    = cur_word[DB+7:DB];
  assign inf_rep = cur_word[DB+8];
  assign yoyo    = cur_word[DB+9];
  assign srev    = cur_word[DB+10];

  alu_op_t       alu_op;
  logic [AW-1:0] alu_a, alu_b, alu_y;
  logic          alu_borrow;

  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state)
      ST_ADD: begin
        alu_op = ALU_ADD;
        alu_a  = AW'(elapsed);
        alu_b  = AW'(dt);
      end
      ST_CMP: begin
        alu_op = ALU_SUB;
        alu_a  = sum;
        alu_b  = AW'(dur);
      end
      ST_PREP: begin
        alu_op = ALU_SUB;
        alu_a  = AW'(elapsed);
        alu_b  = AW'(dur);
      end
      ST_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = AW'({rem, 1'b0});
        alu_b  = AW'(dur);
      end
      ST_FIN: begin
        alu_op = ALU_SUB;
        alu_a  = AW'(ONE_Q16);
        alu_b  = AW'(raw);
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  tss_alu #(.W(AW)) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .y      (alu_y),
    .borrow (alu_borrow)
  );

  // Pass-end decision, shared by the zero-duration and the overflow cases.
  logic [RW-1:0]   pe_dt;
  logic [8:0]      pc_inc;
  logic            pe_rep, pe_next, pe_limit;
  logic [UC_W-1:0] seg_plus1;
  logic [WR_W-1:0] wraps_inc;

  always_comb begin
    pe_dt     = (state == ST_CMP) ? alu_y[RW-1:0] : '0;
    pc_inc    = (pass_counter < PASS_SAT) ? pass_counter + 9'd1 : pass_counter;
    pe_rep    = inf_rep || (pc_inc <= {1'b0, reps});
    seg_plus1 = UC_W'(seg) + UC_W'(1);
    pe_next   = seg_plus1 < used_cnt;
    wraps_inc = wraps + WR_W'(1);
    pe_limit  = wraps_inc >= WR_W'(MAX_WRAPS_PER_TICK);
  end

  logic pass_end;
  assign pass_end = ((state == ST_ADD) && (dur == '0)) ||
                    ((state == ST_CMP) && !alu_borrow);

  // a tick that reaches the pass logic or completes an empty timeline
  logic tick_live;
  assign tick_live = (item.cmd == CMD_TICK) && (item.dt != '0) && (mode == MODE_STARTED);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ret_state    <= ST_PREP;
      mode         <= MODE_STOPPED;
      seg          <= '0;
      elapsed      <= '0;
      pass_counter <= '0;
      rev          <= 1'b0;
      wraps        <= '0;
      wrapped      <= 1'b0;
      advanced     <= 1'b0;
      done_now     <= 1'b0;
      dropped      <= 1'b0;
      bitcnt       <= '0;
    end else begin
      if (pass_end) begin
        wraps <= wraps_inc;
        dt    <= pe_dt;
        if (pe_rep) begin
          if (yoyo) rev <= ~rev;
          elapsed      <= '0;
          pass_counter <= pc_inc;
          wrapped      <= 1'b1;
        end else if (pe_next) begin
          seg          <= seg + SEG_W'(1);
          elapsed      <= '0;
          pass_counter <= '0;
          advanced     <= 1'b1;
        end else begin
          mode         <= MODE_COMPLETED;
          elapsed      <= dur;
          pass_counter <= pc_inc;
          done_now     <= 1'b1;
        end
        if (!pe_rep && !pe_next) begin
          state <= ST_PREP;
        end else begin
          if (pe_dt != '0 && pe_limit) dropped <= 1'b1;
          if (pe_dt == '0 || pe_limit) begin
            ret_state <= ST_PREP;
          end else begin
            ret_state <= ST_ADD;
          end
          // a new segment needs its start direction before going on
          if (pe_rep) begin
            state <= (pe_dt == '0 || pe_limit) ? ST_PREP : ST_ADD;
          end else begin
            state <= ST_LOADREV;
          end
        end
      end else begin
        unique case (state)
          ST_IDLE: begin
            if (start) begin
              wrapped  <= 1'b0;
              advanced <= 1'b0;
              done_now <= tick_live && (used_cnt == '0);
              dropped  <= 1'b0;
              state    <= (tick_live && (used_cnt != '0)) ? ST_ADD : ST_PREP;
              unique case (item.cmd)
                CMD_TICK: begin
                  if (tick_live) begin
                    if (used_cnt == '0) begin
                      mode <= MODE_COMPLETED;
                    end else begin
                      wraps <= '0;
                      dt    <= RW'(item.dt);
                    end
                  end
                end
                CMD_START, CMD_TOGGLE, CMD_RESET: begin
                  if (item.cmd == CMD_TOGGLE && mode == MODE_STARTED) begin
                    mode <= MODE_PAUSED;
                  end else if (item.cmd == CMD_TOGGLE && mode == MODE_PAUSED) begin
                    mode <= MODE_STARTED;
                  end else if (item.cmd == CMD_RESET || mode != MODE_STARTED ||
                               (item.cmd == CMD_START && item.force_start)) begin
                    seg          <= '0;
                    elapsed      <= '0;
                    pass_counter <= '0;
                    rev          <= word0_srev;
                    mode         <= (item.cmd == CMD_RESET) ? MODE_STOPPED : MODE_STARTED;
                  end
                end
                CMD_STOP: begin
                  if (mode == MODE_STARTED || mode == MODE_PAUSED) mode <= MODE_STOPPED;
                end
                CMD_PAUSE: begin
                  if (mode == MODE_STARTED) mode <= MODE_PAUSED;
                end
                CMD_RESUME: begin
                  if (mode == MODE_PAUSED) mode <= MODE_STARTED;
                end
                default: begin
                end
              endcase
            end
          end
          ST_ADD: begin
            // non-zero duration here: pass_end covers the zero case
            sum   <= alu_y;
            state <= ST_CMP;
          end
          ST_CMP: begin
            // pass not finished: time fits inside it
            elapsed <= sum[DB-1:0];
            state   <= ST_PREP;
          end
          ST_LOADREV: begin
            rev   <= srev;
            state <= ret_state;
          end
          ST_PREP: begin
            bitcnt <= '0;
            rem    <= elapsed;
            if (dur == '0) begin
              raw   <= (mode == MODE_COMPLETED) ? ONE_Q16 : '0;
              state <= ST_FIN;
            end else if (!alu_borrow) begin
              raw   <= ONE_Q16;
              state <= ST_FIN;
            end else begin
              raw   <= '0;
              state <= ST_DIV;
            end
          end
          ST_DIV: begin
            rem    <= alu_borrow ? {rem[DB-2:0], 1'b0} : alu_y[DB-1:0];
            raw    <= {raw[15:0], !alu_borrow};
            bitcnt <= bitcnt + 4'd1;
            if (bitcnt == 4'(QBITS - 1)) state <= ST_FIN;
          end
          ST_FIN: begin
            if (out_free) state <= ST_IDLE;
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign cur_seg   = seg;
  assign res_valid = (state == ST_FIN);

  always_comb begin
    res.mode     = mode;
    res.seg      = 2'(seg);
    res.progress = rev ? alu_y[16:0] : raw;
    res.passes   = pass_counter;
    res.reversed = rev;
    res.wrapped  = wrapped;
    res.advanced = advanced;
    res.done_now = done_now;
    res.dropped  = dropped;
  end

`ifndef ASSERT_OFF
  a_pass_sat: assert property (@(posedge clk) disable iff (rst)
    pass_counter <= PASS_SAT)
    else $error("pass counter beyond saturation");

  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    int'(seg) < MAX_SEGMENTS)
    else $error("segment index beyond segment store");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < dur))
    else $error("division remainder not below duration");

  a_wrap_limit: assert property (@(posedge clk) disable iff (rst)
    int'(wraps) <= MAX_WRAPS_PER_TICK)
    else $error("wrap count beyond limit");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_free) |=> (res_valid && $stable(res)))
    else $error("result changed while waiting for output register");
`endif

endmodule

// ===== design/tween_segment_sequencer.sv =====
// Tween segment sequencer: timeline of up to MAX_SEGMENTS segments with
// repeat, yoyo and start-reversed passes, driven by run commands and ticks.
//
// Input stream (s_*): one word per command; s_tuser holds the command,
// s_tdata the tick amount and the force-start flag.
// Output stream (m_*): one status word per input word, in order.
// Config channel (cfg_*): always ready; index 0 is the segment count,
// indexes 1..4 the segment words. Write only while the block is idle.
//
// Each word goes through accept, prepare and finish steps, plus a division
// step for each quotient bit when the elapsed time lies below a non-zero
// duration. A tick adds an add and a compare step per pass it visits (only the
// add for a zero-length pass) and a direction-load step per segment change.
// The single shared add/subtract unit serves each add and compare step of the
// pass loop and each quotient bit. The block takes no word while one is in
// progress. The result sits in an output register, so the next word is
// accepted while it waits; if m_tready stays low the sequencer holds its
// finished result and stalls. Reset clears run state, segment registers and
// the output valid.
module tween_segment_sequencer #(
  parameter int MAX_SEGMENTS       = 4,
  parameter int DURATION_BITS      = 24,
  parameter int MAX_WRAPS_PER_TICK = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // tick_amount[15:0], force_start[16], zero pad [23:17]
  input  logic [tss_pkg::IN_W-1:0]    s_tdata,
  // cmd[2:0]
  input  logic [2:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // run_state[1:0], segment_index[3:2], progress_q16[20:4], passes_done[29:21],
  // is_reversed[30], pass_wrapped[31], segment_advanced[32],
  // completed_now[33], time_dropped[34], zero pad [39:35]
  output logic [tss_pkg::OUT_W-1:0]   m_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [DURATION_BITS+10:0]   cfg_data
);
  import tss_pkg::*;

  localparam int WORD_W = DURATION_BITS + 11;
  localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int UC_W   = $clog2(MAX_SEGMENTS + 1);

  logic [2:0]        seg_count;
  logic [WORD_W-1:0] seg_word [MAX_SEGMENTS];
  logic [UC_W-1:0]   used_cnt;
  logic [SEG_W-1:0]  cur_seg;
  logic [SEG_W-1:0]  widx;
  logic              core_ready, res_valid, out_free;
  res_t              res;
  item_t             item;

  assign cfg_ready = 1'b1;
  assign widx      = SEG_W'(cfg_index - REG_SEG_FIRST);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= '0;
      for (int i = 0; i < MAX_SEGMENTS; i++) seg_word[i] <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SEG_COUNT) begin
        seg_count <= cfg_data[2:0];
      end else if (cfg_index >= REG_SEG_FIRST && cfg_index <= REG_SEG_LAST &&
                   int'(cfg_index) - 1 < MAX_SEGMENTS) begin
        seg_word[widx] <= cfg_data;
      end
    end
  end

  assign used_cnt = (int'(seg_count) > MAX_SEGMENTS) ? UC_W'(MAX_SEGMENTS) : UC_W'(seg_count);

  assign item.cmd         = s_tuser;
  assign item.dt          = s_tdata[15:0];
  assign item.force_start = s_tdata[16];
  assign s_tready         = core_ready;
  assign out_free         = !m_tvalid || m_tready;

  tss_core #(
    .MAX_SEGMENTS       (MAX_SEGMENTS),
    .DURATION_BITS      (DURATION_BITS),
    .MAX_WRAPS_PER_TICK (MAX_WRAPS_PER_TICK)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .start      (s_tvalid && core_ready),
    .item       (item),
    .in_ready   (core_ready),
    .cur_seg    (cur_seg),
    .cur_word   (seg_word[cur_seg]),
    .word0_srev (seg_word[0][DURATION_BITS+10]),
    .used_cnt   (used_cnt),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  // output register: load a finished result, drop the word once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) m_tdata <= OUT_W'(res);
  end

endmodule
